[design/sci_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sci_pkg
// Widths, constants and the square root step of the segment / circle
// intersection pipeline.
// ----------------------------------------------------------------------------
package sci_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int RADIUS_WIDTH = 31;

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(65536);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = ((PROD_W > 2 * RADIUS_WIDTH) ? PROD_W : 2 * RADIUS_WIDTH) + 2;
    localparam int LO_W   = (SUM_W + 1) / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int SQ_W   = 2 * SUM_W;
    localparam int T_W    = FRAC_BITS + 1;
    localparam int RAD_W  = SQ_W + 2 * T_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int NUM_W  = ((SUM_W + FRAC_BITS + 4) > (ROOT_W + 2)) ?
                            (SUM_W + FRAC_BITS + 4) : (ROOT_W + 2);

    localparam int IN_DATA_W   = ((6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((T_W + 7) / 8) * 8;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    function automatic sqrt_state_t sqrt_step(sqrt_state_t cur, logic [1:0] bits);
        sqrt_state_t      res;
        logic [REM_W-1:0] acc;
        logic [REM_W-1:0] trial;
        acc   = {cur.rem[REM_W-3:0], bits};
        trial = {cur.root, 2'b01};
        if (acc >= trial) begin
            res.rem  = acc - trial;
            res.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = acc;
            res.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[design/segment_circle_intersection_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_circle_intersection_top
// Exact segment / circle intersection: quadratic terms, wide discriminant,
// bit-per-stage square root, exact root selection and a bit-per-stage divider.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle unless the output stalls, set by the fully
// pipelined root and divider; a stall holds every stage, nothing dropped or repeated
// reset: synchronous active-low aresetn clears all valid bits, radius = 1.0 m
// ----------------------------------------------------------------------------
module segment_circle_intersection_top (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire [sci_pkg::RADIUS_WIDTH-1:0]     cfg_wr_data,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, end_x, end_y, center_x, center_y
    input  wire [sci_pkg::IN_DATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // param_t
    output logic [sci_pkg::OUT_DATA_W-1:0]      m_tdata,
    // found
    output logic                                m_tuser
);
    import sci_pkg::*;

    logic en;
    logic [RADIUS_WIDTH-1:0] radius_reg;

    // input fields
    logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey, cx, cy;

    // stage 1
    logic                      p1_v_reg;
    logic signed [DIFF_W-1:0]  p1_dx_reg, p1_dy_reg, p1_fx_reg, p1_fy_reg;
    logic [RADIUS_WIDTH-1:0]   p1_r_reg;
    // stage 2
    logic                      p2_v_reg;
    logic signed [PROD_W-1:0]  p2_xx_reg, p2_yy_reg, p2_hx_reg, p2_hy_reg, p2_fx_reg, p2_fy_reg;
    logic [2*RADIUS_WIDTH-1:0] p2_rr_reg;
    // stage 3
    logic                      p3_v_reg;
    logic [SUM_W-1:0]          p3_a_reg;
    logic signed [SUM_W-1:0]   p3_h_reg, p3_c_reg;
    // stage 4
    logic                      p4_v_reg;
    logic [SUM_W-1:0]          p4_a_reg, p4_hm_reg, p4_cm_reg;
    logic signed [SUM_W-1:0]   p4_h_reg;
    logic signed [SUM_W:0]     p4_ah_reg;
    logic signed [NUM_W-1:0]   p4_num_reg;
    logic                      p4_cneg_reg, p4_aok_reg;
    // stage 5
    logic                      p5_v_reg;
    logic [2*LO_W-1:0]         p5_hll_reg, p5_all_reg;
    logic [SUM_W-1:0]          p5_hlh_reg, p5_alh_reg, p5_ahl_reg;
    logic [2*HI_W-1:0]         p5_hhh_reg, p5_ahh_reg;
    logic [SUM_W-1:0]          p5_a_reg;
    logic signed [SUM_W-1:0]   p5_h_reg;
    logic signed [SUM_W:0]     p5_ah_reg;
    logic signed [NUM_W-1:0]   p5_num_reg;
    logic                      p5_cneg_reg, p5_aok_reg;
    // stage 6
    logic                      p6_v_reg;
    logic [SQ_W-1:0]           p6_hsq_reg, p6_acm_reg;
    logic [SUM_W-1:0]          p6_a_reg;
    logic signed [SUM_W-1:0]   p6_h_reg;
    logic signed [SUM_W:0]     p6_ah_reg;
    logic signed [NUM_W-1:0]   p6_num_reg;
    logic                      p6_cneg_reg, p6_aok_reg;

    // square root pipeline
    logic                      q_v_reg    [0:ROOT_W];
    logic [REM_W-1:0]          q_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]         q_root_reg [0:ROOT_W];
    logic [RAD_W-1:0]          q_rad_reg  [0:ROOT_W];
    logic [SUM_W-1:0]          q_a_reg    [0:ROOT_W];
    logic signed [SUM_W-1:0]   q_h_reg    [0:ROOT_W];
    logic signed [SUM_W:0]     q_ah_reg   [0:ROOT_W];
    logic signed [NUM_W-1:0]   q_num_reg  [0:ROOT_W];
    logic                      q_ok_reg   [0:ROOT_W];

    logic [SQ_W:0]             disc_next;
    logic [RAD_W-1:0]          rad_next;

    // divider pipeline
    logic                      dv_v_reg     [0:T_W];
    logic [NUM_W-1:0]          dv_rem_reg   [0:T_W];
    logic [NUM_W-1:0]          dv_d_reg     [0:T_W];
    logic [T_W-1:0]            dv_q_reg     [0:T_W];
    logic                      dv_found_reg [0:T_W];

    // root selection
    logic [ROOT_W-1:0]         root_fin;
    logic [SUM_W-1:0]          s_int;
    logic                      exact, exact_s, h_le0, ah_neg, far, near;
    logic signed [SUM_W+1:0]   sc, hc, ahc, nh, nah;
    logic [NUM_W-1:0]          m_next;

    logic                      m_tvalid_reg, m_tuser_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign sx = $signed(s_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
    assign sy = $signed(s_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
    assign ex = $signed(s_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
    assign ey = $signed(s_tdata[3*COORD_WIDTH +: COORD_WIDTH]);
    assign cx = $signed(s_tdata[4*COORD_WIDTH +: COORD_WIDTH]);
    assign cy = $signed(s_tdata[5*COORD_WIDTH +: COORD_WIDTH]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        disc_next = p6_cneg_reg ? ({1'b0, p6_hsq_reg} + {1'b0, p6_acm_reg})
                                : ({1'b0, p6_hsq_reg} - {1'b0, p6_acm_reg});
        rad_next  = disc_next[SQ_W] ? '0 : {disc_next[SQ_W-1:0], {(2*T_W){1'b0}}};
    end

    always_comb begin
        root_fin = q_root_reg[ROOT_W];
        exact    = (q_rem_reg[ROOT_W] == '0);
        s_int    = root_fin[ROOT_W-1:T_W];
        exact_s  = exact && (root_fin[T_W-1:0] == '0);
        sc       = $signed({2'b00, s_int});
        hc       = (SUM_W+2)'(q_h_reg[ROOT_W]);
        ahc      = (SUM_W+2)'(q_ah_reg[ROOT_W]);
        nh       = -hc;
        nah      = -ahc;
        h_le0    = q_h_reg[ROOT_W][SUM_W-1] || (q_h_reg[ROOT_W] == '0);
        ah_neg   = q_ah_reg[ROOT_W][SUM_W];
        far      = (h_le0 || (sc >= hc)) && !ah_neg &&
                   ((sc < ahc) || ((sc == ahc) && exact_s));
        near     = h_le0 && ((sc < nh) || ((sc == nh) && exact_s)) &&
                   (!ah_neg || (sc >= nah));
        if (far) begin
            m_next = q_num_reg[ROOT_W] + NUM_W'(root_fin);
        end else begin
            m_next = q_num_reg[ROOT_W] - NUM_W'(root_fin) - NUM_W'(!exact);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            p3_v_reg     <= 1'b0;
            p4_v_reg     <= 1'b0;
            p5_v_reg     <= 1'b0;
            p6_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++) begin
                q_v_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= T_W; j++) begin
                dv_v_reg[j] <= 1'b0;
            end
        end else if (en) begin
            p1_v_reg     <= s_tvalid;
            p2_v_reg     <= p1_v_reg;
            p3_v_reg     <= p2_v_reg;
            p4_v_reg     <= p3_v_reg;
            p5_v_reg     <= p4_v_reg;
            p6_v_reg     <= p5_v_reg;
            q_v_reg[0]   <= p6_v_reg;
            for (int k = 0; k < ROOT_W; k++) begin
                q_v_reg[k+1] <= q_v_reg[k];
            end
            dv_v_reg[0]  <= q_v_reg[ROOT_W];
            for (int j = 0; j < T_W; j++) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
            m_tvalid_reg <= dv_v_reg[T_W];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            // differences
            p1_dx_reg <= DIFF_W'(ex) - DIFF_W'(sx);
            p1_dy_reg <= DIFF_W'(ey) - DIFF_W'(sy);
            p1_fx_reg <= DIFF_W'(sx) - DIFF_W'(cx);
            p1_fy_reg <= DIFF_W'(sy) - DIFF_W'(cy);
            p1_r_reg  <= radius_reg;

            // products
            p2_xx_reg <= p1_dx_reg * p1_dx_reg;
            p2_yy_reg <= p1_dy_reg * p1_dy_reg;
            p2_hx_reg <= p1_fx_reg * p1_dx_reg;
            p2_hy_reg <= p1_fy_reg * p1_dy_reg;
            p2_fx_reg <= p1_fx_reg * p1_fx_reg;
            p2_fy_reg <= p1_fy_reg * p1_fy_reg;
            p2_rr_reg <= p1_r_reg * p1_r_reg;

            // quadratic terms
            p3_a_reg <= SUM_W'(p2_xx_reg) + SUM_W'(p2_yy_reg);
            p3_h_reg <= SUM_W'(p2_hx_reg) + SUM_W'(p2_hy_reg);
            p3_c_reg <= SUM_W'(p2_fx_reg) + SUM_W'(p2_fy_reg) - SUM_W'(p2_rr_reg);

            // magnitudes and linear terms
            p4_a_reg    <= p3_a_reg;
            p4_h_reg    <= p3_h_reg;
            p4_hm_reg   <= p3_h_reg[SUM_W-1] ? SUM_W'(-p3_h_reg) : SUM_W'(p3_h_reg);
            p4_cm_reg   <= p3_c_reg[SUM_W-1] ? SUM_W'(-p3_c_reg) : SUM_W'(p3_c_reg);
            p4_cneg_reg <= p3_c_reg[SUM_W-1];
            p4_aok_reg  <= (p3_a_reg != '0);
            p4_ah_reg   <= $signed({2'b00, p3_a_reg[SUM_W-2:0]}) + (SUM_W+1)'(p3_h_reg);
            p4_num_reg  <= $signed(NUM_W'(p3_a_reg)) - (NUM_W'(p3_h_reg) <<< T_W);

            // partial products of h*h and a*|c|
            p5_hll_reg  <= p4_hm_reg[LO_W-1:0] * p4_hm_reg[LO_W-1:0];
            p5_hlh_reg  <= p4_hm_reg[LO_W-1:0] * p4_hm_reg[SUM_W-1:LO_W];
            p5_hhh_reg  <= p4_hm_reg[SUM_W-1:LO_W] * p4_hm_reg[SUM_W-1:LO_W];
            p5_all_reg  <= p4_a_reg[LO_W-1:0] * p4_cm_reg[LO_W-1:0];
            p5_alh_reg  <= p4_a_reg[LO_W-1:0] * p4_cm_reg[SUM_W-1:LO_W];
            p5_ahl_reg  <= p4_a_reg[SUM_W-1:LO_W] * p4_cm_reg[LO_W-1:0];
            p5_ahh_reg  <= p4_a_reg[SUM_W-1:LO_W] * p4_cm_reg[SUM_W-1:LO_W];
            p5_a_reg    <= p4_a_reg;
            p5_h_reg    <= p4_h_reg;
            p5_ah_reg   <= p4_ah_reg;
            p5_num_reg  <= p4_num_reg;
            p5_cneg_reg <= p4_cneg_reg;
            p5_aok_reg  <= p4_aok_reg;

            // full products h*h and a*|c|
            p6_hsq_reg  <= SQ_W'(p5_hll_reg) + (SQ_W'(p5_hlh_reg) << (LO_W + 1)) +
                           (SQ_W'(p5_hhh_reg) << (2 * LO_W));
            p6_acm_reg  <= SQ_W'(p5_all_reg) +
                           ((SQ_W'(p5_alh_reg) + SQ_W'(p5_ahl_reg)) << LO_W) +
                           (SQ_W'(p5_ahh_reg) << (2 * LO_W));
            p6_a_reg    <= p5_a_reg;
            p6_h_reg    <= p5_h_reg;
            p6_ah_reg   <= p5_ah_reg;
            p6_num_reg  <= p5_num_reg;
            p6_cneg_reg <= p5_cneg_reg;
            p6_aok_reg  <= p5_aok_reg;

            // discriminant, scaled radicand
            q_rem_reg[0]  <= '0;
            q_root_reg[0] <= '0;
            q_rad_reg[0]  <= rad_next;
            q_a_reg[0]    <= p6_a_reg;
            q_h_reg[0]    <= p6_h_reg;
            q_ah_reg[0]   <= p6_ah_reg;
            q_num_reg[0]  <= p6_num_reg;
            q_ok_reg[0]   <= p6_aok_reg && !disc_next[SQ_W];

            // one root bit per stage
            for (int k = 0; k < ROOT_W; k++) begin
                {q_rem_reg[k+1], q_root_reg[k+1]} <= sqrt_step(
                    sqrt_state_t'({q_rem_reg[k], q_root_reg[k]}),
                    q_rad_reg[k][RAD_W-1 -: 2]);
                q_rad_reg[k+1] <= q_rad_reg[k] << 2;
                q_a_reg[k+1]   <= q_a_reg[k];
                q_h_reg[k+1]   <= q_h_reg[k];
                q_ah_reg[k+1]  <= q_ah_reg[k];
                q_num_reg[k+1] <= q_num_reg[k];
                q_ok_reg[k+1]  <= q_ok_reg[k];
            end

            // root choice and numerator
            dv_rem_reg[0]   <= m_next;
            dv_d_reg[0]     <= NUM_W'(q_a_reg[ROOT_W]) << 1;
            dv_q_reg[0]     <= '0;
            dv_found_reg[0] <= q_ok_reg[ROOT_W] && (far || near);

            // one quotient bit per stage
            for (int j = 0; j < T_W; j++) begin
                if (dv_rem_reg[j] >= (dv_d_reg[j] << (FRAC_BITS - j))) begin
                    dv_rem_reg[j+1] <= dv_rem_reg[j] - (dv_d_reg[j] << (FRAC_BITS - j));
                    dv_q_reg[j+1]   <= {dv_q_reg[j][T_W-2:0], 1'b1};
                end else begin
                    dv_rem_reg[j+1] <= dv_rem_reg[j];
                    dv_q_reg[j+1]   <= {dv_q_reg[j][T_W-2:0], 1'b0};
                end
                dv_d_reg[j+1]     <= dv_d_reg[j];
                dv_found_reg[j+1] <= dv_found_reg[j];
            end

            m_tuser_reg <= dv_found_reg[T_W];
            m_tdata_reg <= dv_found_reg[T_W] ? OUT_DATA_W'(dv_q_reg[T_W]) : '0;
        end
    end

endmodule
`default_nettype wire
